/* rtl/tfp_pkg.sv */
// ----------------------------------------------------------------------------
// Telemetry frame producer package
// Shared types and constants for the telemetry frame producer.
// ----------------------------------------------------------------------------
package tfp_pkg;

  localparam int FRAME_BYTES = 22;
  localparam int FRAME_BITS  = FRAME_BYTES * 8;
  localparam int BODY_BITS   = FRAME_BITS - 16;
  localparam int HALFWORDS   = BODY_BITS / 16;
  localparam int BYTE_CNT_W  = $clog2(FRAME_BYTES);

  localparam int COUNT_W  = 32;
  localparam int PERIOD_W = 16;
  localparam int DIV_STEPS = COUNT_W;
  localparam int STEP_W   = $clog2(DIV_STEPS);

  localparam int CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] REG_HEARTBEAT_PERIOD = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_RANGE_PERIOD     = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_RANGE_CONFIDENCE = 2'd2;

  localparam logic [15:0] RST_HEARTBEAT_PERIOD = 16'd100;
  localparam logic [15:0] RST_RANGE_PERIOD     = 16'd50;
  localparam logic [15:0] RST_RANGE_CONFIDENCE = 16'd95;
  localparam logic [31:0] RST_NEXT_HEARTBEAT   = 32'd10;
  localparam logic [31:0] RST_NEXT_RANGE       = 32'd20;
  localparam logic [15:0] RST_HEARTBEAT_SEQ    = 16'h2000;
  localparam logic [15:0] RST_RANGE_SEQ        = 16'h0100;
  localparam logic [15:0] RST_HEIGHT           = 16'd185;

  localparam logic [15:0] SYNC_WORD      = 16'hA55A;
  localparam logic [7:0]  TYPE_HEARTBEAT = 8'h50;
  localparam logic [7:0]  TYPE_RANGE     = 8'h51;
  localparam logic [7:0]  TYPE_UNSUPP    = 8'h7E;
  localparam logic [15:0] AUX_HEARTBEAT  = 16'hCAFE;
  localparam logic [15:0] AUX_RANGE      = 16'h3333;
  localparam logic [15:0] AUX_UNSUPP     = 16'h7E7E;
  localparam logic [15:0] SRC_HEARTBEAT  = 16'h0002;
  localparam logic [15:0] SRC_RANGE      = 16'h0003;
  localparam logic [15:0] SRC_UNSUPP     = 16'h0002;
  localparam logic [47:0] PAYLOAD_UNSUPP = 48'h000100020003;
  localparam logic [15:0] HEIGHT_OUT_OF_RANGE = 16'd12000;
  localparam logic [15:0] HEIGHT_UPPER   = 16'd9900;
  localparam logic [15:0] HEIGHT_STEP    = 16'd5;

  localparam int FLAG_CORRUPT_RANGE = 0;
  localparam int FLAG_CORRUPT_HB    = 1;
  localparam int FLAG_OUT_OF_RANGE  = 2;
  localparam int FLAG_LOW_CONF      = 3;

  localparam logic OP_TICK    = 1'b0;
  localparam logic OP_COMMAND = 1'b1;

  localparam logic [3:0] CMD_TOGGLE_HB      = 4'd0;
  localparam logic [3:0] CMD_TOGGLE_RANGE   = 4'd1;
  localparam logic [3:0] CMD_CORRUPT_RANGE  = 4'd2;
  localparam logic [3:0] CMD_CORRUPT_HB     = 4'd3;
  localparam logic [3:0] CMD_OUT_OF_RANGE   = 4'd4;
  localparam logic [3:0] CMD_LOW_CONF       = 4'd5;
  localparam logic [3:0] CMD_UNSUPPORTED    = 4'd6;
  localparam logic [3:0] CMD_HEIGHT_UP      = 4'd7;
  localparam logic [3:0] CMD_HEIGHT_DOWN    = 4'd8;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HB_CHK,
    ST_HB_DIV,
    ST_HB_LOAD,
    ST_RG_CHK,
    ST_RG_DIV,
    ST_RG_LOAD,
    ST_SEND
  } state_t;

endpackage

/* rtl/tfp_rem_unit.sv */
// ----------------------------------------------------------------------------
// Remainder unit
// Restoring divider that produces the remainder of a 32-bit count difference
// by a 16-bit period, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tfp_rem_unit
  import tfp_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [COUNT_W-1:0]  dividend,
  input  logic [PERIOD_W-1:0] divisor,
  output logic                busy,
  output logic [PERIOD_W-1:0] remainder
);

  logic [COUNT_W-1:0]  dvd;
  logic [PERIOD_W-1:0] dsr;
  logic [PERIOD_W-1:0] rem;
  logic [STEP_W-1:0]   step;
  logic [PERIOD_W:0]   rem_shift;
  logic [PERIOD_W:0]   diff;

  assign rem_shift = {rem, dvd[COUNT_W-1]};
  assign diff      = rem_shift - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (start) begin
      busy <= 1'b1;
      step <= '0;
      dvd  <= dividend;
      dsr  <= divisor;
      rem  <= '0;
    end else if (busy) begin
      dvd  <= {dvd[COUNT_W-2:0], 1'b0};
      rem  <= diff[PERIOD_W] ? rem_shift[PERIOD_W-1:0] : diff[PERIOD_W-1:0];
      step <= step + STEP_W'(1);
      if (step == STEP_W'(DIV_STEPS - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  assign remainder = rem;

endmodule

/* rtl/telemetry_frame_producer_core.sv */
// ----------------------------------------------------------------------------
// Telemetry frame producer core
// A command is handled in idle; the unsupported command also emits a 22-byte test frame.
// A tick checks the heartbeat and then the range deadline; each due frame uses the
// shared remainder unit (32 iterations) and then sends 22 byte words.
// The next word is accepted only when the previous one has been fully handled.
// Synchronous active-high reset restores control state, configuration and counters.
// ----------------------------------------------------------------------------
module telemetry_frame_producer_core
  import tfp_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [7:0]             s_tdata,   // operation[0], command[4:1], zero
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [7:0]             m_tdata,   // tx_byte[7:0]
  output logic                   m_tlast,   // frame_end
  output logic                   m_tuser,   // run_end
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [15:0]            cfg_data
);

  state_t state, state_next;

  logic [15:0] hb_period, rg_period, rg_confidence;
  logic [31:0] ms_count, next_hb, next_rg;
  logic [15:0] hb_seq, rg_seq, height;
  logic        hb_on, rg_on;
  logic [3:0]  flags;

  logic [FRAME_BITS-1:0] frame;
  logic [BYTE_CNT_W-1:0] byte_cnt;
  logic                  run_last;
  state_t                send_return;

  logic [15:0] hb_p, rg_p;
  logic [31:0] d_hb, d_rg, ts;
  logic        hb_due, rg_due;
  logic        div_start, div_busy;
  logic [15:0] div_rem;
  logic        in_fire, out_fire, last_byte;
  logic        in_op;
  logic [3:0]  in_cmd;
  logic [15:0] rg_height, rg_conf;

  function automatic logic [FRAME_BITS-1:0] build_frame(
    input logic [7:0]  ftype,
    input logic [15:0] seq,
    input logic [31:0] stamp,
    input logic [47:0] payload,
    input logic [15:0] aux,
    input logic [15:0] src,
    input logic        bad
  );
    logic [BODY_BITS-1:0] body;
    logic [15:0]          sum;
    body = {SYNC_WORD, ftype, 8'h00, seq, stamp, payload, aux, src};
    sum  = {15'd0, bad};
    for (int i = 0; i < HALFWORDS; i++) begin
      sum = sum ^ body[i*16 +: 16];
    end
    return {body, sum};
  endfunction

  assign in_op  = s_tdata[0];
  assign in_cmd = s_tdata[4:1];

  assign hb_p   = (hb_period == 16'd0) ? 16'd1 : hb_period;
  assign rg_p   = (rg_period == 16'd0) ? 16'd1 : rg_period;
  assign d_hb   = ms_count - next_hb;
  assign d_rg   = ms_count - next_rg;
  assign hb_due = hb_on && !d_hb[31];
  assign rg_due = rg_on && !d_rg[31];
  assign ts     = (ms_count << 10) - (ms_count << 4) - (ms_count << 3);

  assign rg_height = flags[FLAG_OUT_OF_RANGE] ? HEIGHT_OUT_OF_RANGE : height;
  assign rg_conf   = flags[FLAG_LOW_CONF] ? 16'd0 : rg_confidence;

  assign s_tready  = (state == ST_IDLE);
  assign m_tvalid  = (state == ST_SEND);
  assign m_tdata   = frame[FRAME_BITS-1 -: 8];
  assign last_byte = (byte_cnt == BYTE_CNT_W'(FRAME_BYTES - 1));
  assign m_tlast   = last_byte;
  assign m_tuser   = last_byte && run_last;
  assign in_fire   = s_tvalid && s_tready;
  assign out_fire  = m_tvalid && m_tready;

  tfp_rem_unit u_rem (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  ((state == ST_HB_CHK) ? d_hb : d_rg),
    .divisor   ((state == ST_HB_CHK) ? hb_p : rg_p),
    .busy      (div_busy),
    .remainder (div_rem)
  );

  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    case (state)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_op == OP_TICK) begin
            state_next = ST_HB_CHK;
          end else if (in_cmd == CMD_UNSUPPORTED) begin
            state_next = ST_SEND;
          end
        end
      end
      ST_HB_CHK: begin
        if (hb_due) begin
          div_start  = 1'b1;
          state_next = ST_HB_DIV;
        end else begin
          state_next = ST_RG_CHK;
        end
      end
      ST_HB_DIV: begin
        if (!div_busy) begin
          state_next = ST_HB_LOAD;
        end
      end
      ST_HB_LOAD: state_next = ST_SEND;
      ST_RG_CHK: begin
        if (rg_due) begin
          div_start  = 1'b1;
          state_next = ST_RG_DIV;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_RG_DIV: begin
        if (!div_busy) begin
          state_next = ST_RG_LOAD;
        end
      end
      ST_RG_LOAD: state_next = ST_SEND;
      ST_SEND: begin
        if (out_fire && last_byte) begin
          state_next = send_return;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hb_period     <= RST_HEARTBEAT_PERIOD;
      rg_period     <= RST_RANGE_PERIOD;
      rg_confidence <= RST_RANGE_CONFIDENCE;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_HEARTBEAT_PERIOD: hb_period     <= cfg_data;
        REG_RANGE_PERIOD:     rg_period     <= cfg_data;
        REG_RANGE_CONFIDENCE: rg_confidence <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ms_count    <= '0;
      next_hb     <= RST_NEXT_HEARTBEAT;
      next_rg     <= RST_NEXT_RANGE;
      hb_seq      <= RST_HEARTBEAT_SEQ;
      rg_seq      <= RST_RANGE_SEQ;
      height      <= RST_HEIGHT;
      hb_on       <= 1'b1;
      rg_on       <= 1'b1;
      flags       <= '0;
      byte_cnt    <= '0;
      run_last    <= 1'b0;
      send_return <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_fire) begin
            if (in_op == OP_TICK) begin
              ms_count <= ms_count + 32'd1;
            end else begin
              case (in_cmd)
                CMD_TOGGLE_HB:     hb_on <= !hb_on;
                CMD_TOGGLE_RANGE:  rg_on <= !rg_on;
                CMD_CORRUPT_RANGE: flags[FLAG_CORRUPT_RANGE] <= 1'b1;
                CMD_CORRUPT_HB:    flags[FLAG_CORRUPT_HB] <= 1'b1;
                CMD_OUT_OF_RANGE:  flags[FLAG_OUT_OF_RANGE] <= 1'b1;
                CMD_LOW_CONF:      flags[FLAG_LOW_CONF] <= 1'b1;
                CMD_UNSUPPORTED: begin
                  frame       <= build_frame(TYPE_UNSUPP, rg_seq, ts, PAYLOAD_UNSUPP,
                                             AUX_UNSUPP, SRC_UNSUPP, 1'b0);
                  rg_seq      <= rg_seq + 16'd1;
                  byte_cnt    <= '0;
                  run_last    <= 1'b1;
                  send_return <= ST_IDLE;
                end
                CMD_HEIGHT_UP: begin
                  if (height < HEIGHT_UPPER) begin
                    height <= height + HEIGHT_STEP;
                  end
                end
                CMD_HEIGHT_DOWN: begin
                  if (height >= HEIGHT_STEP) begin
                    height <= height - HEIGHT_STEP;
                  end
                end
                default: ;
              endcase
            end
          end
        end
        ST_HB_LOAD: begin
          next_hb     <= ms_count - {16'd0, div_rem} + {16'd0, hb_p};
          frame       <= build_frame(TYPE_HEARTBEAT, hb_seq, ts, 48'd0, AUX_HEARTBEAT,
                                     SRC_HEARTBEAT, flags[FLAG_CORRUPT_HB]);
          hb_seq      <= hb_seq + 16'd1;
          flags[FLAG_CORRUPT_HB] <= 1'b0;
          byte_cnt    <= '0;
          run_last    <= !rg_due;
          send_return <= ST_RG_CHK;
        end
        ST_RG_LOAD: begin
          next_rg     <= ms_count - {16'd0, div_rem} + {16'd0, rg_p};
          frame       <= build_frame(TYPE_RANGE, rg_seq, ts,
                                     {rg_height, rg_conf, ts[23:8] ^ rg_seq},
                                     AUX_RANGE, SRC_RANGE, flags[FLAG_CORRUPT_RANGE]);
          rg_seq      <= rg_seq + 16'd1;
          flags[FLAG_CORRUPT_RANGE] <= 1'b0;
          flags[FLAG_OUT_OF_RANGE]  <= 1'b0;
          flags[FLAG_LOW_CONF]      <= 1'b0;
          byte_cnt    <= '0;
          run_last    <= 1'b1;
          send_return <= ST_IDLE;
        end
        ST_SEND: begin
          if (out_fire && !last_byte) begin
            frame    <= {frame[FRAME_BITS-9:0], 8'h00};
            byte_cnt <= byte_cnt + BYTE_CNT_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // The input side is closed whenever a word is on offer.
  a_ready_excl: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !m_tvalid) else $error("input ready while sending");

  // A remainder handed to a deadline update is below its period.
  a_rem_hb: assert property (@(posedge clk) disable iff (rst)
    (state == ST_HB_LOAD) |-> (div_rem < hb_p)) else $error("heartbeat remainder too big");

  a_rem_rg: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RG_LOAD) |-> (div_rem < rg_p)) else $error("range remainder too big");

  // The last frame word leaves the core idle or checking the range deadline.
  a_frame_done: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && m_tlast) |=> (state == ST_IDLE || state == ST_RG_CHK))
    else $error("bad state after frame");

  // The divider is never busy while a frame is being sent.
  a_div_quiet: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !div_busy) else $error("divider busy during send");

endmodule
